### rtl/core/aeti_pkg.sv
// shared types and constants for the escape sequence interpreter
`default_nettype none
package aeti_pkg;
   localparam logic [2:0] CMD_WRITE  = 3'd0;
   localparam logic [2:0] CMD_SCROLL = 3'd1;
   localparam logic [2:0] CMD_CLS    = 3'd2;
   localparam logic [2:0] CMD_CLEOL  = 3'd3;
   localparam logic [2:0] CMD_BELL   = 3'd4;

   localparam logic [7:0] BLANK      = 8'd32;
   localparam logic [7:0] ESC_CODE   = 8'h1b;
   localparam logic [7:0] BEL_CODE   = 8'h07;
   localparam logic [7:0] ATTR_RESET = 8'd7;
   localparam logic [7:0] ATTR_REV   = 8'd112;
   localparam logic [7:0] ATTR_BLINK = 8'd128;

   localparam logic [1:0] REG_ESC  = 2'd0;
   localparam logic [1:0] REG_COLS = 2'd1;
   localparam logic [1:0] REG_ROWS = 2'd2;
   localparam logic [1:0] REG_TAB  = 2'd3;

   // byte classes decoded by the datapath
   localparam logic [3:0] OP_NONE   = 4'd0;
   localparam logic [3:0] OP_GLYPH  = 4'd1;
   localparam logic [3:0] OP_LF     = 4'd2;
   localparam logic [3:0] OP_TAB    = 4'd3;
   localparam logic [3:0] OP_BELL   = 4'd4;
   localparam logic [3:0] OP_CLS    = 4'd5;
   localparam logic [3:0] OP_CLEOL  = 4'd6;
   localparam logic [3:0] OP_SGR    = 4'd7;

   // controller to datapath
   typedef struct packed {
      logic load;       // latch request byte and run the per-byte update
      logic put;        // write a glyph at cursor
      logic feed;       // line feed
      logic scroll_out; // emit pending scroll
      logic sgr_step;   // apply one sgr field
      logic finish;     // clear params after final
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic [3:0] op;
      logic       wrap;     // put wrapped past the bottom row
      logic       scroll;   // line feed needs scroll
      logic       sgr_done; // last sgr field reached
      logic [3:0] tab_n;
   } sts_type;

   function automatic logic [7:0] sgr_apply(input logic [7:0] a, input logic [15:0] c);
      logic [7:0] r;
      r = a;
      case (c)
         16'd0:  r = ATTR_RESET;
         16'd1:  r = a | 8'd8;
         16'd2:  r = a & ~8'd8;
         16'd5:  r = a | ATTR_BLINK;
         16'd7:  r = ATTR_REV;
         16'd8:  r = 8'd0;
         16'd30: r = a & ~8'd7;
         16'd31: r = (a & ~8'd7) | 8'd4;
         16'd32: r = (a & ~8'd7) | 8'd2;
         16'd33: r = (a & ~8'd7) | 8'd6;
         16'd34: r = (a & ~8'd7) | 8'd1;
         16'd35: r = (a & ~8'd7) | 8'd5;
         16'd36: r = (a & ~8'd7) | 8'd3;
         16'd37: r = a | 8'd7;
         16'd40: r = a & ~ATTR_REV;
         16'd41: r = (a & ~ATTR_REV) | 8'h40;
         16'd42: r = (a & ~ATTR_REV) | 8'h20;
         16'd43: r = (a & ~ATTR_REV) | 8'h60;
         16'd44: r = (a & ~ATTR_REV) | 8'h10;
         16'd45: r = (a & ~ATTR_REV) | 8'h50;
         16'd46: r = (a & ~ATTR_REV) | 8'h30;
         16'd47: r = a | ATTR_REV;
         default: r = a;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

### rtl/core/aeti_ctrl.sv
// sequencer: walks each request byte through its output commands
`default_nettype none
module aeti_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic                   rsp_last,
   output logic [2:0]             out_sel,
   input  wire aeti_pkg::sts_type sts,
   output aeti_pkg::ctl_type      ctl
);
   import aeti_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DEC    = 3'd1;
   localparam logic [2:0] S_EMIT   = 3'd2;
   localparam logic [2:0] S_SCROLL = 3'd3;
   localparam logic [2:0] S_SGR    = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [3:0] left_ff, left_in;   // tab glyphs still to write
   logic [2:0] sel_ff, sel_in;
   logic       last_ff, last_in;
   logic       vld_ff, vld_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = vld_ff;
   assign rsp_last  = last_ff;
   assign out_sel   = sel_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      left_in  = left_ff;
      sel_in   = sel_ff;
      last_in  = last_ff;
      vld_in   = vld_ff;
      ctl      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            case (sts.op)
               OP_GLYPH: begin
                  ctl.put = 1'b1; left_in = 4'd0;
                  sel_in = CMD_WRITE; vld_in = 1'b1;
                  last_in = !sts.scroll; state_in = S_EMIT;
               end
               OP_TAB: begin
                  ctl.put = 1'b1; left_in = sts.tab_n - 4'd1;
                  sel_in = CMD_WRITE; vld_in = 1'b1;
                  last_in = !sts.scroll && (sts.tab_n == 4'd1);
                  state_in = S_EMIT;
               end
               OP_LF: begin
                  ctl.feed = 1'b1; left_in = 4'd0;
                  if (sts.scroll) begin
                     sel_in = CMD_SCROLL; vld_in = 1'b1; last_in = 1'b1;
                     state_in = S_EMIT;
                  end else state_in = S_IDLE;
               end
               OP_BELL: begin
                  left_in = 4'd0; sel_in = CMD_BELL; vld_in = 1'b1;
                  last_in = 1'b1; state_in = S_EMIT;
               end
               OP_CLS: begin
                  ctl.finish = 1'b1; left_in = 4'd0; sel_in = CMD_CLS;
                  vld_in = 1'b1; last_in = 1'b1; state_in = S_EMIT;
               end
               OP_CLEOL: begin
                  ctl.finish = 1'b1; left_in = 4'd0; sel_in = CMD_CLEOL;
                  vld_in = 1'b1; last_in = 1'b1; state_in = S_EMIT;
               end
               OP_SGR: state_in = S_SGR;
               default: state_in = S_IDLE;
            endcase
         end
         S_SGR: begin
            ctl.sgr_step = 1'b1;
            if (sts.sgr_done) begin
               ctl.finish = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (rsp_ready) begin
               vld_in = 1'b0;
               if (sel_ff == CMD_WRITE && sts.wrap) begin
                  sel_in = CMD_SCROLL; vld_in = 1'b1;
                  last_in = (left_ff == 4'd0);
               end else if (left_ff != 4'd0) begin
                  state_in = S_SCROLL;
               end else state_in = S_IDLE;
            end
         end
         S_SCROLL: begin
            // next tab glyph
            ctl.put = 1'b1; left_in = left_ff - 4'd1;
            sel_in = CMD_WRITE; vld_in = 1'b1;
            last_in = !sts.scroll && (left_ff == 4'd1);
            state_in = S_EMIT;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vld_ff   <= 1'b0;
         left_ff  <= 4'd0;
         sel_ff   <= CMD_WRITE;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
         left_ff  <= left_in;
         sel_ff   <= sel_in;
         last_ff  <= last_in;
      end
   end
endmodule
`default_nettype wire

### rtl/core/aeti_dp.sv
// datapath: cursor, attribute, parser state and parameter fields
`default_nettype none
module aeti_dp #(
   parameter int MAX_PARAMS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [7:0]        req_text_byte,
   input  wire logic              esc_en,
   input  wire logic [7:0]        cols_raw,
   input  wire logic [5:0]        rows_raw,
   input  wire logic [3:0]        tab_raw,
   input  wire logic [2:0]        out_sel,
   input  wire aeti_pkg::ctl_type ctl,
   output aeti_pkg::sts_type      sts,
   output logic [7:0]             rsp_column,
   output logic [5:0]             rsp_row,
   output logic [7:0]             rsp_glyph,
   output logic [7:0]             rsp_attribute
);
   import aeti_pkg::*;

   localparam int PW = $clog2(MAX_PARAMS);
   localparam logic [PW-1:0] LASTP = PW'(MAX_PARAMS - 1);

   logic [7:0]  byte_ff;
   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  col_ff, col_in, wcol_ff;
   logic [5:0]  row_ff, row_in, wrow_ff, srow_ff, srow_in;
   logic [7:0]  attr_ff, attr_in, wattr_ff;
   logic [7:0]  scol_ff, scol_in;
   logic        sval_ff, sval_in;
   logic [15:0] pv_ff [MAX_PARAMS];
   logic [PW-1:0] pc_ff, pc_in, sk_ff, sk_in;
   logic        closed_ff, closed_in, seen_ff, seen_in;
   logic [3:0]  op_ff, op_in;
   logic        wrap_ff, wrap_in, clr_p, dig_w;
   logic [15:0] dig_v;
   logic [7:0]  cols, cm1;
   logic [5:0]  rows, rm1;
   logic [3:0]  tabn;

   // clamped screen geometry
   always_comb begin
      cols = (cols_raw < 8'd16) ? 8'd16 : (cols_raw > 8'd132) ? 8'd132 : cols_raw;
      rows = (rows_raw < 6'd2) ? 6'd2 : (rows_raw > 6'd60) ? 6'd60 : rows_raw;
      tabn = (tab_raw < 4'd1) ? 4'd1 : (tab_raw > 4'd8) ? 4'd8 : tab_raw;
      cm1 = cols - 8'd1;
      rm1 = rows - 6'd1;
   end

   assign sts.op       = op_ff;
   assign sts.wrap     = wrap_ff;
   assign sts.scroll   = ctl.put ? ((col_ff == cm1) && (row_ff == rm1)) : (row_ff == rm1);
   assign sts.sgr_done = (sk_ff == pc_ff);
   assign sts.tab_n    = tabn;

   // output field select
   always_comb begin
      rsp_column = 8'd0; rsp_row = 6'd0; rsp_glyph = BLANK; rsp_attribute = attr_ff;
      case (out_sel)
         CMD_WRITE:  begin
            rsp_column = wcol_ff; rsp_row = wrow_ff;
            rsp_glyph = (op_ff == OP_TAB) ? BLANK : byte_ff; rsp_attribute = wattr_ff;
         end
         CMD_SCROLL: rsp_row = rm1;
         CMD_CLS:    ;
         CMD_CLEOL:  begin rsp_column = col_ff; rsp_row = row_ff; end
         CMD_BELL:   begin rsp_glyph = BEL_CODE; rsp_attribute = 8'd0; end
         default:    ;
      endcase
   end

   // per-byte decode and state update
   always_comb begin
      logic [7:0]  b, c0;
      logic [5:0]  r0;
      logic [1:0]  ph;
      logic [15:0] p0, p1;
      logic [16:0] t;
      logic [19:0] acc;
      b = req_text_byte;
      phase_in = phase_ff; col_in = col_ff; row_in = row_ff; attr_in = attr_ff;
      scol_in = scol_ff; srow_in = srow_ff; sval_in = sval_ff;
      pc_in = pc_ff; closed_in = closed_ff; seen_in = seen_ff; sk_in = sk_ff;
      op_in = op_ff; wrap_in = wrap_ff; clr_p = 1'b0; dig_w = 1'b0; dig_v = 16'd0;
      p0 = pv_ff[0]; p1 = pv_ff[1]; t = 17'd0; acc = 20'd0;
      c0 = (col_ff > cm1) ? cm1 : col_ff;
      r0 = (row_ff > rm1) ? rm1 : row_ff;
      ph = esc_en ? phase_ff : 2'd0;
      if (ctl.load) begin
         op_in = OP_NONE; sk_in = '0;
         if (b != 8'd0) begin
            col_in = c0; row_in = r0; phase_in = ph;
            case (ph)
               2'd0: begin
                  case (b)
                     ESC_CODE: if (esc_en) phase_in = 2'd1; else col_in = 8'd0;
                     8'h0d: col_in = 8'd0;
                     8'h0a: op_in = OP_LF;
                     8'h09: op_in = OP_TAB;
                     8'h08: if (c0 != 8'd0) col_in = c0 - 8'd1;
                     BEL_CODE: op_in = OP_BELL;
                     default: op_in = OP_GLYPH;
                  endcase
               end
               2'd1: begin
                  phase_in = (b == "[") ? 2'd2 : 2'd0;
                  if (b == "[") clr_p = 1'b1;
               end
               2'd2: begin
                  if (b inside {"H","F","A","B","C","D","n","s","u","J","K","m","p"}) begin
                     phase_in = 2'd0;
                     clr_p = 1'b1;
                     case (b)
                        "H", "F": begin
                           if (!seen_ff) begin col_in = 8'd0; row_in = 6'd0; end
                           if (p0 >= 16'd1 && pc_ff >= PW'(1) && p1 >= 16'd1) begin
                              row_in = ((p0 - 16'd1) > {10'd0, rm1}) ? rm1 : 6'(p0 - 16'd1);
                              col_in = ((p1 - 16'd1) > {8'd0, cm1}) ? cm1 : 8'(p1 - 16'd1);
                           end
                        end
                        "A": begin
                           t = {1'b0, (p0 == 16'd0) ? 16'd1 : p0};
                           row_in = (t >= {11'd0, r0}) ? 6'd0 : r0 - 6'(t);
                        end
                        "B": begin
                           t = {1'b0, (p0 == 16'd0) ? 16'd1 : p0} + {11'd0, r0};
                           row_in = (t > {11'd0, rm1}) ? rm1 : 6'(t);
                        end
                        "C": begin
                           t = {1'b0, (p0 == 16'd0) ? 16'd1 : p0} + {9'd0, c0};
                           col_in = (t > {9'd0, cm1}) ? cm1 : 8'(t);
                        end
                        "D": begin
                           t = {1'b0, (p0 == 16'd0) ? 16'd1 : p0};
                           col_in = (t >= {9'd0, c0}) ? 8'd0 : c0 - 8'(t);
                        end
                        "s": begin scol_in = c0; srow_in = r0; sval_in = 1'b1; end
                        "u": if (sval_ff) begin
                           col_in = (scol_ff > cm1) ? cm1 : scol_ff;
                           row_in = (srow_ff > rm1) ? rm1 : srow_ff;
                           sval_in = 1'b0;
                        end
                        "J": begin op_in = OP_CLS; clr_p = 1'b0; end
                        "K": begin op_in = OP_CLEOL; clr_p = 1'b0; end
                        "m": if (seen_ff) begin op_in = OP_SGR; clr_p = 1'b0; end
                        default: ;
                     endcase
                  end else begin
                     seen_in = 1'b1;
                     if (b >= "0" && b <= "9") begin
                        if (!closed_ff) begin
                           // wide enough for the saturating compare
                           acc = {4'd0, pv_ff[pc_ff]} * 20'd10 + {12'd0, b - "0"};
                           dig_w = 1'b1;
                           dig_v = (acc > 20'd65535) ? 16'hffff : acc[15:0];
                        end
                     end else if (b == ";") begin
                        if (pc_ff < LASTP) begin pc_in = pc_ff + PW'(1); closed_in = 1'b0; end
                        else closed_in = 1'b1;
                     end else closed_in = 1'b1;
                  end
               end
               default: phase_in = 2'd0;
            endcase
         end
      end
      // cell write advance, scroll flagged only on the bottom row
      if (ctl.put) begin
         wrap_in = (col_ff == cm1) && (row_ff == rm1);
         col_in = (col_ff == cm1) ? 8'd0 : col_ff + 8'd1;
         if (col_ff == cm1 && row_ff != rm1) row_in = row_ff + 6'd1;
      end
      if (ctl.feed && row_ff != rm1) row_in = row_ff + 6'd1;
      if (ctl.sgr_step) begin
         attr_in = sgr_apply(attr_ff, pv_ff[sk_ff]);
         if (sk_ff != pc_ff) sk_in = sk_ff + PW'(1);
      end
      if (ctl.finish) begin
         clr_p = 1'b1;
         if (op_ff == OP_CLS) begin col_in = 8'd0; row_in = 6'd0; end
      end
      if (clr_p) begin pc_in = '0; closed_in = 1'b0; seen_in = 1'b0; end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0; col_ff <= 8'd0; row_ff <= 6'd0; attr_ff <= ATTR_RESET;
         scol_ff <= 8'd0; srow_ff <= 6'd0; sval_ff <= 1'b0;
         pc_ff <= '0; closed_ff <= 1'b0; seen_ff <= 1'b0; sk_ff <= '0;
         op_ff <= OP_NONE; wrap_ff <= 1'b0;
         for (int i = 0; i < MAX_PARAMS; i++) pv_ff[i] <= 16'd0;
      end else begin
         phase_ff <= phase_in; col_ff <= col_in; row_ff <= row_in; attr_ff <= attr_in;
         scol_ff <= scol_in; srow_ff <= srow_in; sval_ff <= sval_in;
         pc_ff <= pc_in; closed_ff <= closed_in; seen_ff <= seen_in; sk_ff <= sk_in;
         op_ff <= op_in; wrap_ff <= wrap_in;
         if (clr_p) for (int i = 0; i < MAX_PARAMS; i++) pv_ff[i] <= 16'd0;
         else if (dig_w) pv_ff[pc_ff] <= dig_v;
      end
   end

   // latched byte and write target
   always_ff @(posedge clock) begin
      if (ctl.load) byte_ff <= req_text_byte;
      if (ctl.put) begin
         wcol_ff <= col_ff; wrow_ff <= row_ff; wattr_ff <= attr_ff;
      end
   end
endmodule
`default_nettype wire

### rtl/core/ansi_escape_terminal_interpreter.sv
// A request is registered into a decode state and its first command into the emit state; a new
// byte is taken only once every command of the last one is taken, and each further tab cell is
// set up in a state of its own between commands; sgr walks one field a cycle through the
// parameter registers.
// Reset: synchronous active high; cursor home, attribute 7, registers to defaults.
`default_nettype none
module ansi_escape_terminal_interpreter #(
   parameter int MAX_PARAMS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_text_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_command,
   output logic [7:0]       rsp_column,
   output logic [5:0]       rsp_row,
   output logic [7:0]       rsp_glyph,
   output logic [7:0]       rsp_attribute,
   output logic             rsp_last,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import aeti_pkg::*;

   logic       esc_ff;
   logic [7:0] cols_ff;
   logic [5:0] rows_ff;
   logic [3:0] tab_ff;
   ctl_type    ctl;
   sts_type    sts;
   logic [2:0] sel;

   assign pready = 1'b1;
   assign rsp_command = sel;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff <= 1'b1; cols_ff <= 8'd80; rows_ff <= 6'd25; tab_ff <= 4'd8;
      end else if (psel && penable && pwrite) begin
         case (paddr[3:2])
            REG_ESC:  esc_ff  <= pwdata[0];
            REG_COLS: cols_ff <= pwdata[7:0];
            REG_ROWS: rows_ff <= pwdata[5:0];
            REG_TAB:  tab_ff  <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (paddr[3:2])
         REG_ESC:  prdata = {31'd0, esc_ff};
         REG_COLS: prdata = {24'd0, cols_ff};
         REG_ROWS: prdata = {26'd0, rows_ff};
         REG_TAB:  prdata = {28'd0, tab_ff};
         default:  prdata = 32'd0;
      endcase
   end

   aeti_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .rsp_last, .out_sel(sel), .sts, .ctl
   );

   aeti_dp #(.MAX_PARAMS(MAX_PARAMS)) u_dp (
      .clock, .reset, .req_text_byte, .esc_en(esc_ff), .cols_raw(cols_ff),
      .rows_raw(rows_ff), .tab_raw(tab_ff), .out_sel(sel), .ctl, .sts,
      .rsp_column, .rsp_row, .rsp_glyph, .rsp_attribute
   );
endmodule
`default_nettype wire

### test/testbench.sv
// self-checking testbench for the ansi escape sequence interpreter
module testbench;
   import aeti_pkg::*;

   localparam int NPARAM = 16;
   localparam longint CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] column;
      logic [5:0] row;
      logic [7:0] glyph;
      logic [7:0] attribute;
      logic       last;
   } screen_cmd_t;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [7:0]  req_text_byte = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [2:0]  rsp_command;
   logic [7:0]  rsp_column;
   logic [5:0]  rsp_row;
   logic [7:0]  rsp_glyph;
   logic [7:0]  rsp_attribute;
   logic        rsp_last;
   logic        psel = 0;
   logic        penable = 0;
   logic        pwrite = 0;
   logic [3:0]  paddr = 0;
   logic [31:0] pwdata = 0;
   logic [31:0] prdata;
   logic        pready;

   ansi_escape_terminal_interpreter dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_text_byte(req_text_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_command(rsp_command),
      .rsp_column(rsp_column), .rsp_row(rsp_row), .rsp_glyph(rsp_glyph),
      .rsp_attribute(rsp_attribute), .rsp_last(rsp_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   // terminal shadow state
   logic        esc_on;
   logic [7:0]  cols_reg;
   logic [5:0]  rows_reg;
   logic [3:0]  tab_reg;
   logic [1:0]  phase;
   logic [7:0]  cur_col;
   logic [5:0]  cur_row;
   logic [7:0]  attr;
   logic [7:0]  sav_col;
   logic [5:0]  sav_row;
   logic        sav_ok;
   logic [15:0] params [NPARAM];
   int          pidx;
   logic        pclosed;
   logic        args_seen;

   screen_cmd_t expected_cmds[$];
   int          errors = 0;
   int          sent_bytes = 0;
   int          got_cmds = 0;
   longint      cycles = 0;
   logic        rx_idle_on = 1;
   logic        tx_idle_on = 1;
   logic        hold_off = 0;

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   function automatic int ecols();
      return cols_reg < 16 ? 16 : (cols_reg > 132 ? 132 : int'(cols_reg));
   endfunction
   function automatic int erows();
      return rows_reg < 2 ? 2 : (rows_reg > 60 ? 60 : int'(rows_reg));
   endfunction

   function automatic void clear_fields();
      for (int i = 0; i < NPARAM; i++) params[i] = 0;
      pidx = 0;
      pclosed = 0;
      args_seen = 0;
   endfunction

   function automatic void push_cmd(logic [2:0] c, int col, int row, logic [7:0] g,
                                    logic [7:0] a);
      screen_cmd_t s;
      s.command = c;
      s.column = col[7:0];
      s.row = row[5:0];
      s.glyph = g;
      s.attribute = a;
      s.last = 0;
      expected_cmds.push_back(s);
   endfunction

   function automatic void feed_line();
      if (int'(cur_row) + 1 > erows() - 1) begin
         push_cmd(CMD_SCROLL, 0, erows() - 1, BLANK, attr);
         cur_row = 6'(erows() - 1);
      end else cur_row = cur_row + 6'd1;
   endfunction

   function automatic void put_cell(logic [7:0] g);
      push_cmd(CMD_WRITE, int'(cur_col), int'(cur_row), g, attr);
      if (int'(cur_col) + 1 > ecols() - 1) begin
         cur_col = 0;
         feed_line();
      end else cur_col = cur_col + 8'd1;
   endfunction

   function automatic logic [7:0] sgr_next(logic [7:0] a, logic [15:0] c);
      case (c)
         0: return ATTR_RESET;
         1: return a | 8'd8;
         2: return a & ~8'd8;
         5: return a | ATTR_BLINK;
         7: return ATTR_REV;
         8: return 8'd0;
         30: return a & ~8'd7;
         31: return (a & ~8'd7) | 8'd4;
         32: return (a & ~8'd7) | 8'd2;
         33: return (a & ~8'd7) | 8'd6;
         34: return (a & ~8'd7) | 8'd1;
         35: return (a & ~8'd7) | 8'd5;
         36: return (a & ~8'd7) | 8'd3;
         37: return a | 8'd7;
         40: return a & ~ATTR_REV;
         41: return (a & ~ATTR_REV) | 8'h40;
         42: return (a & ~ATTR_REV) | 8'h20;
         43: return (a & ~ATTR_REV) | 8'h60;
         44: return (a & ~ATTR_REV) | 8'h10;
         45: return (a & ~ATTR_REV) | 8'h50;
         46: return (a & ~ATTR_REV) | 8'h30;
         47: return a | ATTR_REV;
         default: return a;
      endcase
   endfunction

   function automatic bit is_final_byte(logic [7:0] b);
      case (b)
         "H", "F", "A", "B", "C", "D", "n", "s", "u", "J", "K", "m", "p": return 1;
         default: return 0;
      endcase
   endfunction

   // carry out a csi final byte
   function automatic void run_final(logic [7:0] b);
      int cnt;
      int lastf;
      int c = ecols();
      int r = erows();
      cnt = params[0] == 0 ? 1 : int'(params[0]);
      case (b)
         "H", "F": begin
            if (!args_seen) begin
               cur_col = 0;
               cur_row = 0;
            end
            if (params[0] >= 1 && pidx >= 1 && params[1] >= 1) begin
               cur_row = 6'((int'(params[0]) - 1 > r - 1) ? r - 1 : int'(params[0]) - 1);
               cur_col = 8'((int'(params[1]) - 1 > c - 1) ? c - 1 : int'(params[1]) - 1);
            end
         end
         "A": cur_row = 6'((cnt >= int'(cur_row)) ? 0 : int'(cur_row) - cnt);
         "B": cur_row = 6'((cnt + int'(cur_row) > r - 1) ? r - 1 : cnt + int'(cur_row));
         "C": cur_col = 8'((cnt + int'(cur_col) > c - 1) ? c - 1 : cnt + int'(cur_col));
         "D": cur_col = 8'((cnt >= int'(cur_col)) ? 0 : int'(cur_col) - cnt);
         "s": begin
            sav_col = cur_col;
            sav_row = cur_row;
            sav_ok = 1;
         end
         "u": if (sav_ok) begin
            cur_col = (int'(sav_col) > c - 1) ? 8'(c - 1) : sav_col;
            cur_row = (int'(sav_row) > r - 1) ? 6'(r - 1) : sav_row;
            sav_ok = 0;
         end
         "J": begin
            push_cmd(CMD_CLS, 0, 0, BLANK, attr);
            cur_col = 0;
            cur_row = 0;
         end
         "K": push_cmd(CMD_CLEOL, int'(cur_col), int'(cur_row), BLANK, attr);
         "m": if (args_seen) begin
            lastf = pidx >= NPARAM ? NPARAM - 1 : pidx;
            for (int k = 0; k <= lastf; k++) attr = sgr_next(attr, params[k]);
         end
         default: ;
      endcase
   endfunction

   // predict the commands caused by one byte
   function automatic void interpret_byte(logic [7:0] b);
      int prior_count;
      int t;
      int idx;
      int v;
      prior_count = expected_cmds.size();
      if (b == 0) return;
      if (int'(cur_col) > ecols() - 1) cur_col = 8'(ecols() - 1);
      if (int'(cur_row) > erows() - 1) cur_row = 6'(erows() - 1);
      if (!esc_on) phase = 0;
      case (phase)
         0: case (b)
            ESC_CODE: if (esc_on) phase = 1; else cur_col = 0;
            8'h0d: cur_col = 0;
            8'h0a: feed_line();
            8'h09: begin
               t = tab_reg < 1 ? 1 : (tab_reg > 8 ? 8 : int'(tab_reg));
               for (int k = 0; k < t; k++) put_cell(BLANK);
            end
            8'h08: if (cur_col != 0) cur_col = cur_col - 8'd1;
            BEL_CODE: push_cmd(CMD_BELL, 0, 0, 8'd7, 8'd0);
            default: put_cell(b);
         endcase
         1: if (b == "[") begin
            phase = 2;
            clear_fields();
         end else phase = 0;
         2: if (is_final_byte(b)) begin
            run_final(b);
            phase = 0;
            clear_fields();
         end else begin
            args_seen = 1;
            idx = pidx >= NPARAM ? NPARAM - 1 : pidx;
            if (b >= "0" && b <= "9") begin
               if (!pclosed) begin
                  v = int'(params[idx]) * 10 + int'(b - "0");
                  params[idx] = v > 65535 ? 16'hffff : v[15:0];
               end
            end else if (b == ";") begin
               if (idx < NPARAM - 1) begin
                  pidx = idx + 1;
                  pclosed = 0;
               end else pclosed = 1;
            end else pclosed = 1;
         end
         default: phase = 0;
      endcase
      if (expected_cmds.size() > prior_count) expected_cmds[$].last = 1;
   endfunction

   // result checker
   always @(posedge clock) begin
      screen_cmd_t e;
      if (!reset && rsp_valid && rsp_ready) begin
         got_cmds <= got_cmds + 1;
         if (expected_cmds.size() == 0) begin
            $error("unexpected command %0d", rsp_command);
            errors++;
         end else begin
            e = expected_cmds.pop_front();
            if (rsp_command !== e.command) begin
               $error("command exp %0d got %0d", e.command, rsp_command); errors++;
            end
            if (rsp_column !== e.column) begin
               $error("column exp %0d got %0d", e.column, rsp_column); errors++;
            end
            if (rsp_row !== e.row) begin
               $error("row exp %0d got %0d", e.row, rsp_row); errors++;
            end
            if (rsp_glyph !== e.glyph) begin
               $error("glyph exp %0d got %0d", e.glyph, rsp_glyph); errors++;
            end
            if (rsp_attribute !== e.attribute) begin
               $error("attribute exp %0d got %0d", e.attribute, rsp_attribute); errors++;
            end
            if (rsp_last !== e.last) begin
               $error("last exp %0d got %0d", e.last, rsp_last); errors++;
            end
         end
      end
   end

   // receiver side with random stalls and an optional long hold-off
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (hold_off) rsp_ready <= 0;
         else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 0;
            n = $urandom_range(1, 15);
            repeat (n - 1) @(negedge clock);
         end else rsp_ready <= 1;
      end
   end

   // send one byte and predict its commands on acceptance; valid drops only
   // for an idle gap or when the stream pauses in drain
   task automatic send_byte(logic [7:0] b);
      if (tx_idle_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_valid <= 1;
      req_text_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      interpret_byte(b);
      sent_bytes++;
      @(negedge clock);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (expected_cmds.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] index, logic [31:0] value);
      drain();
      psel <= 1; pwrite <= 1; paddr <= {index, 2'b00}; pwdata <= value; penable <= 0;
      @(negedge clock);
      penable <= 1;
      @(negedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      case (index)
         REG_ESC: esc_on = value[0];
         REG_COLS: cols_reg = value[7:0];
         REG_ROWS: rows_reg = value[5:0];
         default: tab_reg = value[3:0];
      endcase
   endtask

   // random csi sequence with random content
   task automatic send_random_csi();
      string finals = "HFABCDnsuJKmp";
      int nf;
      send_byte(ESC_CODE);
      send_byte("[");
      nf = $urandom_range(0, 3);
      for (int f = 0; f < nf; f++) begin
         if ($urandom_range(0, 1)) send_byte(8'("0" + $urandom_range(0, 9)));
         if ($urandom_range(0, 2) == 0) send_byte(8'("0" + $urandom_range(0, 9)));
         if ($urandom_range(0, 9) == 0) send_byte(" ");
         if (f < nf - 1 || $urandom_range(0, 5) == 0) send_byte(";");
      end
      send_byte(finals[$urandom_range(0, 12)]);
   endtask

   task automatic test_directed();
      send_text("Hi\t");
      send_byte(8'hff);
      send_byte(8'h00);
      send_byte(8'h0d); send_byte(8'h0a); send_byte(8'h08); send_byte(BEL_CODE);
      send_text("\033[5;10H\033[2A\033[3B\033[C\033[9D\033[s\033[u\033[u");
      send_text("\033[1;31;44mX\033[mY\033[0m\033[K\033[J\033[+5H\033[;H\033[H");
      send_text("\033x\033[99999;999F");
      send_text("\033[1;2;3;4;5;6;7;8;9;10;11;12;13;14;15;16;17;41m\033[n\033[pZ");
   endtask

   task automatic test_small_screen();
      write_reg(REG_COLS, 0);
      write_reg(REG_ROWS, 0);
      write_reg(REG_TAB, 0);
      repeat (40) send_byte(8'($urandom_range(32, 126)));
      send_text("\t\n\n\n\033[99B\033[99C\033[u");
      write_reg(REG_COLS, 255);
      write_reg(REG_ROWS, 63);
      write_reg(REG_TAB, 15);
      send_text("\033[60;132H\033[s\033[200;200HQ\t");
      write_reg(REG_COLS, 16);
      write_reg(REG_ROWS, 2);
      send_text("\033[uAB\n");
   endtask

   task automatic test_escape_disabled();
      write_reg(REG_ESC, 0);
      send_text("ab\033[2Jcd");
      send_byte(ESC_CODE);
      write_reg(REG_ESC, 1);
      write_reg(REG_COLS, 80);
      write_reg(REG_ROWS, 25);
      write_reg(REG_TAB, 8);
   endtask

   task automatic test_random_mix(int count);
      int start;
      start = sent_bytes;
      while (sent_bytes - start < count) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: send_random_csi();
            4: send_byte(8'($urandom_range(0, 255)));
            5: send_byte(ESC_CODE);
            6: send_byte(8'($urandom_range(7, 13)));
            default: send_byte(8'($urandom_range(32, 126)));
         endcase
      end
   endtask

   task automatic test_backpressure();
      hold_off = 1;
      fork
         begin
            repeat (300) @(negedge clock);
            hold_off = 0;
         end
         repeat (30) send_byte("\t");
      join
   endtask

   initial begin
      esc_on = 1; cols_reg = 80; rows_reg = 25; tab_reg = 8;
      phase = 0; cur_col = 0; cur_row = 0; attr = ATTR_RESET;
      sav_col = 0; sav_row = 0; sav_ok = 0;
      clear_fields();
      repeat (3) @(negedge clock);
      reset <= 0;
      test_directed();
      test_small_screen();
      test_escape_disabled();
      test_backpressure();
      write_reg(REG_COLS, 20);
      write_reg(REG_ROWS, 4);
      write_reg(REG_TAB, 3);
      test_random_mix(100);
      write_reg(REG_COLS, 132);
      write_reg(REG_ROWS, 60);
      test_random_mix(60);
      rx_idle_on = 0;
      tx_idle_on = 0;
      test_random_mix(40);
      drain();
      $display("covered %0d bytes and %0d commands: text, controls, csi moves, sgr,",
               sent_bytes, got_cmds);
      $display("clears, save/restore, screen sizes at both ends, escape off, stalls");
      if (errors == 0 && expected_cmds.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end
endmodule
